[sv/pse_pkg.sv]
`default_nettype none

package pse_pkg;

  // data widths of the token and result fields
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned OPND_W  = 31;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned DIV_STEP_W = $clog2(WORD_W);

  // value returned by a pop from an empty stack
  localparam logic [WORD_W-1:0] POP_EMPTY = '1;

  // token operation codes, codes above OP_UNKNOWN behave as unknown
  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_UNKNOWN = 3'd5
  } op_e;

endpackage

`default_nettype wire

[sv/pse_in_if.sv]
`default_nettype none

interface pse_in_if;
  logic                            valid;
  logic                            ready;
  logic [pse_pkg::OP_W-1:0]        op;
  logic [pse_pkg::OPND_W-1:0]      operand;
  logic                            last;

  modport source (output valid, output op, output operand, output last, input ready);
  modport sink   (input valid, input op, input operand, input last, output ready);
endinterface

`default_nettype wire

[sv/pse_out_if.sv]
`default_nettype none

interface pse_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [pse_pkg::WORD_W-1:0] result;
  logic                            underflow_seen;
  logic                            overflow_seen;
  logic                            divide_by_zero;

  modport source (output valid, output result, output underflow_seen,
                  output overflow_seen, output divide_by_zero, input ready);
  modport sink   (input valid, input result, input underflow_seen,
                  input overflow_seen, input divide_by_zero, output ready);
endinterface

`default_nettype wire

[sv/postfix_stack_evaluator.sv]
// Postfix expression evaluator over a stack held in a synchronous RAM.
// in_i carries one token per transfer (op, operand, last); out_o carries
// one result per expression, on the token marked last.
// A token is taken only while the sequencer is idle, so tokens are handled
// one at a time; the stack RAM read port is registered. Sequencer steps:
//   push operand             push
//   add, subtract, multiply  pop right, pop left, execute, push
//   divide                   as above with 32-step restoring divider if divisor nonzero
//   unknown operator         pop right, pop left, no push
//   last token               then a final pop into the output register
// The result sits in an output register; the next expression's tokens are
// taken while it waits. A last token whose result finds that register still
// full waits in the final pop until the receiver takes the old result.
// Reset empties the stack (count to zero) and clears the sticky flags and
// the output valid; the RAM contents are left as they are and never read
// before being written.
`default_nettype none

module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  pse_in_if.sink     in_i,
  pse_out_if.source  out_o
);

  localparam int unsigned W      = pse_pkg::WORD_W;
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SW     = pse_pkg::DIV_STEP_W;

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_POP_R   = 4'd1;
  localparam logic [3:0] S_POP_L   = 4'd2;
  localparam logic [3:0] S_EXEC    = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_DIV_END = 4'd5;
  localparam logic [3:0] S_PUSH    = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;
  localparam logic [3:0] S_FIN_W   = 4'd8;

  logic [3:0]              state_q, state_d;
  logic [pse_pkg::OP_W-1:0] op_q, op_d;
  logic                    last_q, last_d;
  logic [W-1:0]            acc_q, acc_d;
  logic [W-1:0]            right_q, right_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic                    pend_q, pend_d;
  logic                    uf_q, uf_d;
  logic                    ovf_q, ovf_d;
  logic                    dz_q, dz_d;

  logic [W-1:0]            div_rem_q, div_rem_d;
  logic [W-1:0]            div_quo_q, div_quo_d;
  logic [W-1:0]            div_den_q, div_den_d;
  logic [SW-1:0]           div_step_q, div_step_d;
  logic                    div_neg_q, div_neg_d;

  logic                    out_valid_q, out_valid_d;
  logic [W-1:0]            res_q, res_d;
  logic                    res_uf_q, res_ovf_q, res_dz_q;
  logic                    res_load;

  // stack ram
  logic [W-1:0]            mem [STACK_DEPTH];
  logic [W-1:0]            rd_data_q;
  logic                    mem_we, mem_re;
  logic [ADDR_W-1:0]       mem_waddr, mem_raddr;

  logic [W-1:0]            pop_val;
  logic                    pop_issue;
  logic                    out_free;
  logic [W:0]              rem_sh, rem_diff;
  logic [CNT_W-1:0]        cnt_dec;

  assign pop_val  = pend_q ? rd_data_q : pse_pkg::POP_EMPTY;
  assign out_free = !out_valid_q || out_o.ready;
  assign cnt_dec  = cnt_q - CNT_W'(1);
  assign rem_sh   = {div_rem_q, div_quo_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, div_den_q};

  assign in_i.ready = (state_q == S_IDLE);

  // sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    last_d     = last_q;
    acc_d      = acc_q;
    right_d    = right_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    uf_d       = uf_q;
    ovf_d      = ovf_q;
    dz_d       = dz_q;
    div_rem_d  = div_rem_q;
    div_quo_d  = div_quo_q;
    div_den_d  = div_den_q;
    div_step_d = div_step_q;
    div_neg_d  = div_neg_q;
    mem_we     = 1'b0;
    mem_waddr  = cnt_q[ADDR_W-1:0];
    pop_issue  = 1'b0;
    res_load   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d   = in_i.op;
          last_d = in_i.last;
          acc_d  = {1'b0, in_i.operand};
          state_d = (in_i.op == pse_pkg::OP_PUSH) ? S_PUSH : S_POP_R;
        end
      end
      S_POP_R: begin
        pop_issue = 1'b1;
        state_d   = S_POP_L;
      end
      S_POP_L: begin
        right_d   = pop_val;
        pop_issue = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_PUSH;
        case (op_q)
          pse_pkg::OP_ADD: acc_d = pop_val + right_q;
          pse_pkg::OP_SUB: acc_d = pop_val - right_q;
          pse_pkg::OP_MUL: acc_d = pop_val * right_q;
          pse_pkg::OP_DIV: begin
            if (right_q == '0) begin
              acc_d = '0;
              dz_d  = 1'b1;
            end else begin
              div_neg_d  = pop_val[W-1] ^ right_q[W-1];
              div_quo_d  = pop_val[W-1] ? (W'(0) - pop_val) : pop_val;
              div_den_d  = right_q[W-1] ? (W'(0) - right_q) : right_q;
              div_rem_d  = '0;
              div_step_d = SW'(W - 1);
              state_d    = S_DIV;
            end
          end
          default: state_d = last_q ? S_FIN : S_IDLE;
        endcase
      end
      S_DIV: begin
        // one restoring step per cycle
        if (!rem_diff[W]) begin
          div_rem_d = rem_diff[W-1:0];
          div_quo_d = {div_quo_q[W-2:0], 1'b1};
        end else begin
          div_rem_d = rem_sh[W-1:0];
          div_quo_d = {div_quo_q[W-2:0], 1'b0};
        end
        div_step_d = div_step_q - SW'(1);
        if (div_step_q == '0) begin
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        acc_d   = div_neg_q ? (W'(0) - div_quo_q) : div_quo_q;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (cnt_q == CNT_W'(STACK_DEPTH)) begin
          ovf_d = 1'b1;
        end else begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
        end
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        // final pop waits for a free output register
        if (out_free) begin
          pop_issue = 1'b1;
          state_d   = S_FIN_W;
        end
      end
      S_FIN_W: begin
        res_load = 1'b1;
        cnt_d    = '0;
        uf_d     = 1'b0;
        ovf_d    = 1'b0;
        dz_d     = 1'b0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // shared pop: empty stack yields all ones and flags underflow
    mem_re    = 1'b0;
    mem_raddr = cnt_dec[ADDR_W-1:0];
    if (pop_issue) begin
      if (cnt_q == '0) begin
        uf_d   = 1'b1;
        pend_d = 1'b0;
      end else begin
        mem_re = 1'b1;
        cnt_d  = cnt_dec;
        pend_d = 1'b1;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_load) begin
      out_valid_d = 1'b1;
    end
    res_d = res_load ? pop_val : res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      uf_q        <= 1'b0;
      ovf_q       <= 1'b0;
      dz_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      uf_q        <= uf_d;
      ovf_q       <= ovf_d;
      dz_q        <= dz_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    last_q     <= last_d;
    acc_q      <= acc_d;
    right_q    <= right_d;
    div_rem_q  <= div_rem_d;
    div_quo_q  <= div_quo_d;
    div_den_q  <= div_den_d;
    div_step_q <= div_step_d;
    div_neg_q  <= div_neg_d;
    res_q      <= res_d;
    if (res_load) begin
      res_uf_q  <= uf_q;
      res_ovf_q <= ovf_q;
      res_dz_q  <= dz_q;
    end
  end

  // stack ram ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= acc_q;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.result         = res_q;
  assign out_o.underflow_seen = res_uf_q;
  assign out_o.overflow_seen  = res_ovf_q;
  assign out_o.divide_by_zero = res_dz_q;

endmodule

`default_nettype wire
